// File: sv/dqhr_pkg.sv
// ----------------------------------------------------------------------------
// dqhr_pkg
// Command and status codes and phase codes of the deque with half rotation.
// ----------------------------------------------------------------------------
package dqhr_pkg;

    // Command codes carried on the command input.
    localparam logic [2:0] CMD_PUSH_HEAD = 3'd0;
    localparam logic [2:0] CMD_PUSH_TAIL = 3'd1;
    localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
    localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
    localparam logic [2:0] CMD_SWAP      = 3'd4;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Reversal passes of the half swap.
    localparam logic [1:0] PH_LEFT  = 2'd0;
    localparam logic [1:0] PH_RIGHT = 2'd1;
    localparam logic [1:0] PH_ALL   = 2'd2;

endpackage

// File: sv/deque_with_half_rotation.sv
// ----------------------------------------------------------------------------
// deque_with_half_rotation
// Inserts, failed removes, short swaps and unknown commands strobe their
// result from the decode state; removes strobe it from S_POP once the RAM
// read returns. Busy holds off a new command until the last one is done.
// A swap of n entries makes k = floor(s/2) + floor((n-s)/2) + floor(n/2)
// exchanges, s = floor(n/2), each through the single RAM port and the shared ring adder.
// Reset (synchronous, active low) empties the queue; the store needs no clear.
// ----------------------------------------------------------------------------
module deque_with_half_rotation #(
    parameter int DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic signed [31:0] o_popped_value,
    output logic [1:0]         o_status,
    output logic [10:0]        o_entry_count
);

    // Ring index width and the width of the fill count, which must reach DEPTH.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a command beat
    localparam logic [2:0] S_DEC  = 3'd1;  // decode, end access, most results
    localparam logic [2:0] S_POP  = 3'd2;  // read data of a remove returns
    localparam logic [2:0] S_CHK  = 3'd3;  // swap: test span, next pass
    localparam logic [2:0] S_RA   = 3'd4;  // swap: read low element
    localparam logic [2:0] S_RB   = 3'd5;  // swap: read high element
    localparam logic [2:0] S_WA   = 3'd6;  // swap: write high value low
    localparam logic [2:0] S_WB   = 3'd7;  // swap: write low value high

    // Control registers.
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_phase, n_phase;
    logic          r_out_valid, n_out_valid;

    // Payload registers.
    logic [2:0]    r_cmd;
    logic [31:0]   r_val;
    logic [AW-1:0] r_lo, n_lo;
    logic [AW-1:0] r_hi, n_hi;
    logic [31:0]   r_tmp, n_tmp;
    logic [31:0]   r_out_pop, n_out_pop;
    logic [1:0]    r_out_status, n_out_status;
    logic [CW-1:0] r_out_count, n_out_count;

    // RAM port.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    // Shared ring unit: head plus a logical position, wrapped once.
    logic [AW-1:0] ring_log;
    logic [AW:0]   ring_sum;
    logic [AW-1:0] ring_pos;

    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] count_dec;
    logic [CW-1:0] half;
    logic [CW-1:0] half_dec;
    logic          is_full;
    logic          is_empty;
    logic          accept;
    logic [CW+10:0] out_count_ext;

    assign accept    = start && !busy;
    assign is_full   = (r_count == FULL_CNT);
    assign is_empty  = (r_count == '0);
    assign count_inc = r_count + CW'(1);
    assign count_dec = r_count - CW'(1);
    assign half      = r_count >> 1;
    assign half_dec  = half - CW'(1);
    assign head_dec  = (r_head == '0) ? LAST_POS : r_head - AW'(1);
    assign head_inc  = (r_head == LAST_POS) ? '0 : r_head + AW'(1);

    // During a swap the unit maps the low pointer on the read and write of the
    // low element and the high pointer on those of the high one; in decode it maps the tail.
    always_comb begin
        unique case (r_state)
            S_RA, S_WA: ring_log = r_lo;
            S_RB, S_WB: ring_log = r_hi;
            default: begin
                if (r_cmd == dqhr_pkg::CMD_POP_TAIL) begin
                    ring_log = count_dec[AW-1:0];
                end else begin
                    ring_log = r_count[AW-1:0];
                end
            end
        endcase
    end

    assign ring_sum = {1'b0, r_head} + {1'b0, ring_log};
    assign ring_pos = (ring_sum >= DEPTH_X) ? AW'(ring_sum - DEPTH_X) : ring_sum[AW-1:0];

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_phase      = r_phase;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_tmp        = r_tmp;
        n_out_valid  = 1'b0;
        n_out_pop    = r_out_pop;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = ring_pos;
        ram_wdata    = r_val;
        ram_raddr    = ring_pos;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                n_state      = S_IDLE;
                n_out_pop    = '0;
                n_out_status = dqhr_pkg::ST_OK;
                n_out_count  = r_count;
                unique case (r_cmd)
                    dqhr_pkg::CMD_PUSH_HEAD: begin
                        n_out_valid = 1'b1;
                        if (is_full) begin
                            n_out_status = dqhr_pkg::ST_FULL;
                        end else begin
                            ram_we      = 1'b1;
                            ram_waddr   = head_dec;
                            n_head      = head_dec;
                            n_count     = count_inc;
                            n_out_count = count_inc;
                        end
                    end
                    dqhr_pkg::CMD_PUSH_TAIL: begin
                        n_out_valid = 1'b1;
                        if (is_full) begin
                            n_out_status = dqhr_pkg::ST_FULL;
                        end else begin
                            ram_we      = 1'b1;
                            n_count     = count_inc;
                            n_out_count = count_inc;
                        end
                    end
                    dqhr_pkg::CMD_POP_HEAD: begin
                        if (is_empty) begin
                            n_out_valid  = 1'b1;
                            n_out_status = dqhr_pkg::ST_EMPTY;
                        end else begin
                            ram_raddr = r_head;
                            n_head    = head_inc;
                            n_count   = count_dec;
                            n_state   = S_POP;
                        end
                    end
                    dqhr_pkg::CMD_POP_TAIL: begin
                        if (is_empty) begin
                            n_out_valid  = 1'b1;
                            n_out_status = dqhr_pkg::ST_EMPTY;
                        end else begin
                            n_count = count_dec;
                            n_state = S_POP;
                        end
                    end
                    dqhr_pkg::CMD_SWAP: begin
                        if (r_count < CW'(2)) begin
                            n_out_valid = 1'b1;
                        end else begin
                            n_lo    = '0;
                            n_hi    = half_dec[AW-1:0];
                            n_phase = dqhr_pkg::PH_LEFT;
                            n_state = S_CHK;
                        end
                    end
                    default: begin
                        n_out_valid = 1'b1;
                    end
                endcase
            end

            S_POP: begin
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
                n_out_pop    = ram_rdata;
                n_out_status = dqhr_pkg::ST_OK;
                n_out_count  = r_count;
            end

            S_CHK: begin
                if (r_lo < r_hi) begin
                    n_state = S_RA;
                end else begin
                    unique case (r_phase)
                        dqhr_pkg::PH_LEFT: begin
                            n_lo    = half[AW-1:0];
                            n_hi    = count_dec[AW-1:0];
                            n_phase = dqhr_pkg::PH_RIGHT;
                        end
                        dqhr_pkg::PH_RIGHT: begin
                            n_lo    = '0;
                            n_hi    = count_dec[AW-1:0];
                            n_phase = dqhr_pkg::PH_ALL;
                        end
                        default: begin
                            n_state      = S_IDLE;
                            n_out_valid  = 1'b1;
                            n_out_pop    = '0;
                            n_out_status = dqhr_pkg::ST_OK;
                            n_out_count  = r_count;
                        end
                    endcase
                end
            end

            S_RA: begin
                n_state = S_RB;
            end

            S_RB: begin
                n_tmp   = ram_rdata;
                n_state = S_WA;
            end

            S_WA: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_state   = S_WB;
            end

            S_WB: begin
                ram_we    = 1'b1;
                ram_wdata = r_tmp;
                n_lo      = r_lo + AW'(1);
                n_hi      = r_hi - AW'(1);
                n_state   = S_CHK;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_phase     <= dqhr_pkg::PH_LEFT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_tmp        <= n_tmp;
        r_out_pop    <= n_out_pop;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    dqhr_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The count port is 11 bits wide whatever DEPTH is.
    assign out_count_ext  = {11'b0, r_out_count};

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_popped_value = r_out_pop;
    assign o_status       = r_out_status;
    assign o_entry_count  = out_count_ext[10:0];

    // A result beat never lasts more than one cycle.
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // Every command that ends delivers its result as the block goes idle.
    a_done_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_valid)
        else $error("command finished without a result beat");

    // A full report only comes from a queue that holds DEPTH entries.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dqhr_pkg::ST_FULL) |-> (r_count == FULL_CNT))
        else $error("full status with room left");

    // Element moves of a swap leave head and count alone.
    a_swap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |=> ($stable(r_head) && $stable(r_count)))
        else $error("swap step disturbed head or count");

endmodule

// File: sv/dqhr_ram.sv
// ----------------------------------------------------------------------------
// dqhr_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dqhr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: test/deque_with_half_rotation_test.sv
// ----------------------------------------------------------------------------
// deque_with_half_rotation_test
// Self-checking bench for the deque with half rotation. A software copy of
// the queue predicts every result beat, and a scoreboard class compares each
// strobed result with the oldest prediction. The stimulus is a short directed
// opening, then random traffic that stays small, fills the queue to the top,
// works at full, and finally runs from a high level with mixed commands.
// ----------------------------------------------------------------------------
module deque_with_half_rotation_test;

    localparam int DEPTH = 1024;

    // Command codes that the block must ignore.
    localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One predicted result beat.
    typedef struct packed {
        logic signed [31:0] popped;
        logic [1:0]         status;
        logic [10:0]        count;
    } t_deque_result;

    // The scoreboard keeps its own copy of the held sequence, head first,
    // and a queue of predicted result beats in command order.
    class deque_tracker;
        logic signed [31:0] held_values[$];
        t_deque_result      predicted_results[$];
        int                 error_count;

        function new();
            error_count = 0;
        endfunction

        function int held_count();
            return held_values.size();
        endfunction

        function int outstanding();
            return predicted_results.size();
        endfunction

        // Apply one accepted command to the copy and predict its result.
        function void note_command(logic [2:0] cmd, logic signed [31:0] val);
            t_deque_result res;
            int            half;
            res.popped = '0;
            res.status = dqhr_pkg::ST_OK;
            case (cmd)
                dqhr_pkg::CMD_PUSH_HEAD, dqhr_pkg::CMD_PUSH_TAIL: begin
                    if (held_values.size() >= DEPTH) begin
                        res.status = dqhr_pkg::ST_FULL;
                    end else if (cmd == dqhr_pkg::CMD_PUSH_HEAD) begin
                        held_values.push_front(val);
                    end else begin
                        held_values.push_back(val);
                    end
                end
                dqhr_pkg::CMD_POP_HEAD: begin
                    if (held_values.size() == 0) begin
                        res.status = dqhr_pkg::ST_EMPTY;
                    end else begin
                        res.popped = held_values.pop_front();
                    end
                end
                dqhr_pkg::CMD_POP_TAIL: begin
                    if (held_values.size() == 0) begin
                        res.status = dqhr_pkg::ST_EMPTY;
                    end else begin
                        res.popped = held_values.pop_back();
                    end
                end
                dqhr_pkg::CMD_SWAP: begin
                    // Rotating left by half the count brings the middle
                    // element to the head; fewer than two entries stay put.
                    half = held_values.size() / 2;
                    repeat (half) held_values.push_back(held_values.pop_front());
                end
                default: begin
                end
            endcase
            res.count = 11'(held_values.size());
            predicted_results.push_back(res);
        endfunction

        function void check_result(logic signed [31:0] popped, logic [1:0] status,
                                   logic [10:0] count);
            t_deque_result want;
            if (predicted_results.size() == 0) begin
                $error("result beat with no command waiting: popped %0d status %0d count %0d",
                       popped, status, count);
                error_count++;
                return;
            end
            want = predicted_results.pop_front();
            if (popped !== want.popped) begin
                $error("popped_value: expected %0d, actual %0d", want.popped, popped);
                error_count++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                error_count++;
            end
            if (count !== want.count) begin
                $error("entry_count: expected %0d, actual %0d", want.count, count);
                error_count++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_command = dqhr_pkg::CMD_PUSH_HEAD;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic signed [31:0] o_popped_value;
    logic [1:0]         o_status;
    logic [10:0]        o_entry_count;

    deque_tracker tracker = new();

    // When set, the sender drops start for random cycles between beats.
    bit gaps_on = 1'b1;

    deque_with_half_rotation #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // The monitor samples at the rising edge, where it sees the values that
    // were stable through the cycle just ended. A command beat is taken when
    // start is high and busy is low; a result beat whenever o_valid is high.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                tracker.check_result(o_popped_value, o_status, o_entry_count);
            end
            if (start && !busy) begin
                tracker.note_command(i_command, i_value);
            end
        end
    end

    // Idle cycles before a beat, about a quarter of the time. While idle the
    // command and value lines carry junk that the block must not pick up.
    task automatic sender_gap();
        while (gaps_on && $urandom_range(99) < 24) begin
            start     <= 1'b0;
            i_command <= 3'($urandom);
            i_value   <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // Present one command beat and hold it until the block takes it. Entered
    // and left at a rising edge, so back-to-back beats keep start high.
    task automatic send_command(input logic [2:0] cmd, input logic signed [31:0] val);
        sender_gap();
        start     <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold the sender off until every predicted result has come back. One
    // edge passes first so that the monitor has noted the last command beat.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // One random command drawn from the given weights; the value is random
    // for every command, so removes and swaps also see ignored data.
    task automatic send_random(input int w_push, input int w_pop, input int w_swap,
                               input int w_undef);
        int         pick;
        logic [2:0] cmd;
        pick = $urandom_range(w_push + w_pop + w_swap + w_undef - 1);
        if (pick < w_push) begin
            cmd = $urandom_range(1) ? dqhr_pkg::CMD_PUSH_TAIL : dqhr_pkg::CMD_PUSH_HEAD;
        end else if (pick < w_push + w_pop) begin
            cmd = $urandom_range(1) ? dqhr_pkg::CMD_POP_TAIL : dqhr_pkg::CMD_POP_HEAD;
        end else if (pick < w_push + w_pop + w_swap) begin
            cmd = dqhr_pkg::CMD_SWAP;
        end else begin
            cmd = 3'($urandom_range(CMD_UNDEF_LAST, CMD_UNDEF_FIRST));
        end
        send_command(cmd, $urandom);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: removes and swap on an empty queue, a swap with a
        // single entry, the value extremes at both ends, swaps of two, three
        // and four entries, the ignored command codes, and draining back to
        // empty through both ends.
        send_command(dqhr_pkg::CMD_POP_HEAD, VAL_MAX);
        send_command(dqhr_pkg::CMD_POP_TAIL, VAL_MIN);
        send_command(dqhr_pkg::CMD_SWAP, 32'sd0);
        send_command(dqhr_pkg::CMD_PUSH_HEAD, VAL_MIN);
        send_command(dqhr_pkg::CMD_SWAP, 32'sd1);
        send_command(dqhr_pkg::CMD_PUSH_TAIL, VAL_MAX);
        send_command(dqhr_pkg::CMD_SWAP, -32'sd1);
        send_command(dqhr_pkg::CMD_PUSH_HEAD, -32'sd1);
        send_command(dqhr_pkg::CMD_SWAP, 32'sd0);
        send_command(dqhr_pkg::CMD_PUSH_TAIL, 32'sd0);
        send_command(dqhr_pkg::CMD_SWAP, VAL_MAX);
        send_command(CMD_UNDEF_FIRST, 32'sd5);
        send_command(3'(CMD_UNDEF_FIRST + 3'd1), 32'sd6);
        send_command(CMD_UNDEF_LAST, VAL_MIN);
        send_command(dqhr_pkg::CMD_POP_HEAD, 32'sd0);
        send_command(dqhr_pkg::CMD_POP_TAIL, 32'sd0);
        send_command(dqhr_pkg::CMD_POP_HEAD, 32'sd0);
        send_command(dqhr_pkg::CMD_POP_TAIL, 32'sd0);
        send_command(dqhr_pkg::CMD_POP_TAIL, 32'sd0);
        send_command(dqhr_pkg::CMD_POP_HEAD, 32'sd0);
        wait_for_results();

        // Small levels: the queue wanders near empty, so empty removes and
        // short swaps of every small size come up often.
        repeat (300) send_random(40, 40, 15, 5);
        wait_for_results();

        // Fill to the top without any idle cycles. Swaps here are long, since
        // the block walks every held entry, so they are kept rare.
        gaps_on = 1'b0;
        while (tracker.held_count() < DEPTH) send_random(94, 3, 3, 0);
        gaps_on = 1'b1;

        // Around full: inserts are refused, removes make room again, and a
        // few swaps run over the whole store.
        repeat (40) send_random(50, 35, 10, 5);
        wait_for_results();

        // Mixed traffic from a high level.
        repeat (250) send_random(45, 45, 5, 5);

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (tracker.error_count == 0 && tracker.outstanding() == 0) begin
            $display("** deque_with_half_rotation: PASSED **");
        end else begin
            $display("** deque_with_half_rotation: FAILED **");
        end
        $finish;
    end

    // Watchdog far beyond the longest expected run, full-store swaps included.
    initial begin
        #40_000_000;
        $display("** deque_with_half_rotation: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
sv/dqhr_pkg.sv
sv/dqhr_ram.sv
sv/deque_with_half_rotation.sv
test/deque_with_half_rotation_test.sv
